// ===== rtl/clfs_pkg.sv =====
`default_nettype none

package clfs_pkg;

   localparam int MAX_LINE = 512;
   localparam int IDX_W    = $clog2(MAX_LINE + 1);
   localparam int POS_W    = 10;
   localparam int BYTE_W   = 8;
   localparam int RSP_W    = 88;

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SENDER,
      PH_CMD_BEGIN,
      PH_CMD,
      PH_TGT_BEGIN,
      PH_TGT,
      PH_MSG_BEGIN,
      PH_MSG
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/chat_line_field_splitter_top.sv =====
`default_nettype none

// Splits one chat protocol text line, one byte per request, into its fields: optional
// colon prefix (sender and nick), command, optional target and trailing message. A byte
// is taken in every cycle while the result register is free or being drained; a line
// of n bytes gives one result in the cycle after its last byte, and the next line may
// start in the cycle right after that byte. Bytes beyond the first MAX_LINE (512) of a
// line are not parsed and raise too_long. All the per-byte work is one phase update
// and a few compares and increments ahead of the state registers.
module chat_line_field_splitter_top
   import clfs_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire  [BYTE_W-1:0]  req_tdata,   // [7:0] line_byte
   input  wire                req_tlast,   // last_byte
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   // [0] has_prefix, [10:1] sender_len, [20:11] nick_len, [30:21] command_start,
   // [40:31] command_len, [41] has_target, [51:42] target_start, [61:52] target_len,
   // [71:62] message_start, [81:72] message_len, [82] too_long, [87:83] zero
   output logic [RSP_W-1:0]   rsp_tdata
);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic             prefix_seen_ff, prefix_seen_in;
   logic [IDX_W-1:0] sender_len_ff, sender_len_in;
   logic [IDX_W-1:0] nick_len_ff, nick_len_in;
   logic             bang_seen_ff, bang_seen_in;
   logic [IDX_W-1:0] cmd_start_ff, cmd_start_in;
   logic [IDX_W-1:0] cmd_len_ff, cmd_len_in;
   logic             target_seen_ff, target_seen_in;
   logic [IDX_W-1:0] tgt_start_ff, tgt_start_in;
   logic [IDX_W-1:0] tgt_len_ff, tgt_len_in;
   logic [IDX_W-1:0] msg_start_ff, msg_start_in;
   logic             overflow_ff, overflow_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             line_full;
   logic             parse;
   logic             is_colon, is_space, is_bang;
   logic             cmd_begin;

   logic [IDX_W-1:0] res_cmd_start, res_cmd_len, res_msg_start, res_msg_len;
   logic [IDX_W-1:0] res_tgt_start, res_tgt_len;
   logic             res_cmd_absent;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign line_full  = byte_index_ff >= IDX_W'(MAX_LINE);
   assign parse      = req_fire && !line_full;
   assign is_colon   = req_tdata == CH_COLON;
   assign is_space   = req_tdata == CH_SPACE;
   assign is_bang    = req_tdata == CH_BANG;
   assign cmd_begin  = (phase_ff == PH_CMD_BEGIN) || ((phase_ff == PH_IDLE) && !is_colon);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (parse) begin
         case (phase_ff)
            PH_IDLE: begin
               if (is_colon) phase_in = PH_SENDER;
               else if (is_space) phase_in = PH_TGT_BEGIN;
               else phase_in = PH_CMD;
            end
            PH_SENDER: begin
               if (is_space) phase_in = PH_CMD_BEGIN;
            end
            PH_CMD_BEGIN: begin
               if (is_space) phase_in = PH_TGT_BEGIN;
               else phase_in = PH_CMD;
            end
            PH_CMD: begin
               if (is_space) phase_in = PH_TGT_BEGIN;
            end
            PH_TGT_BEGIN: begin
               if (is_colon) phase_in = PH_MSG;
               else if (is_space) phase_in = PH_MSG_BEGIN;
               else phase_in = PH_TGT;
            end
            PH_TGT: begin
               if (is_space) phase_in = PH_MSG_BEGIN;
            end
            PH_MSG_BEGIN: phase_in = PH_MSG;
            PH_MSG:       phase_in = PH_MSG;
            default:      phase_in = PH_IDLE;
         endcase
      end
   end

   // field positions and lengths
   always_comb begin
      byte_index_in  = byte_index_ff;
      prefix_seen_in = prefix_seen_ff;
      sender_len_in  = sender_len_ff;
      nick_len_in    = nick_len_ff;
      bang_seen_in   = bang_seen_ff;
      cmd_start_in   = cmd_start_ff;
      cmd_len_in     = cmd_len_ff;
      target_seen_in = target_seen_ff;
      tgt_start_in   = tgt_start_ff;
      tgt_len_in     = tgt_len_ff;
      msg_start_in   = msg_start_ff;
      overflow_in    = overflow_ff || (req_fire && line_full);
      if (parse) begin
         byte_index_in = byte_index_ff + IDX_W'(1);
         if ((phase_ff == PH_IDLE) && is_colon) begin
            prefix_seen_in = 1'b1;
         end
         if ((phase_ff == PH_SENDER) && !is_space) begin
            if (is_bang) bang_seen_in = 1'b1;
            else if (!bang_seen_ff) nick_len_in = nick_len_ff + IDX_W'(1);
            sender_len_in = sender_len_ff + IDX_W'(1);
         end
         if (cmd_begin) begin
            cmd_start_in = byte_index_ff;
            cmd_len_in   = is_space ? IDX_W'(0) : IDX_W'(1);
         end
         if ((phase_ff == PH_CMD) && !is_space) begin
            cmd_len_in = cmd_len_ff + IDX_W'(1);
         end
         if (phase_ff == PH_TGT_BEGIN) begin
            if (is_colon) begin
               msg_start_in = byte_index_ff + IDX_W'(1);
            end else begin
               target_seen_in = 1'b1;
               tgt_start_in   = byte_index_ff;
               tgt_len_in     = is_space ? IDX_W'(0) : IDX_W'(1);
            end
         end
         if ((phase_ff == PH_TGT) && !is_space) begin
            tgt_len_in = tgt_len_ff + IDX_W'(1);
         end
         if (phase_ff == PH_MSG_BEGIN) begin
            msg_start_in = is_colon ? byte_index_ff + IDX_W'(1) : byte_index_ff;
         end
      end
   end

   // result from the state after this byte
   always_comb begin
      res_cmd_absent = (phase_in == PH_SENDER) || (phase_in == PH_CMD_BEGIN) ||
                       (phase_in == PH_IDLE);
      res_cmd_start  = res_cmd_absent ? byte_index_in : cmd_start_in;
      res_cmd_len    = res_cmd_absent ? IDX_W'(0) : cmd_len_in;
      res_msg_start  = (phase_in == PH_MSG) ? msg_start_in : byte_index_in;
      res_msg_len    = byte_index_in - res_msg_start;
      res_tgt_start  = target_seen_in ? tgt_start_in : IDX_W'(0);
      res_tgt_len    = target_seen_in ? tgt_len_in : IDX_W'(0);
      rsp_data_in    = {5'd0,
                        overflow_in,
                        POS_W'(res_msg_len),
                        POS_W'(res_msg_start),
                        POS_W'(res_tgt_len),
                        POS_W'(res_tgt_start),
                        target_seen_in,
                        POS_W'(res_cmd_len),
                        POS_W'(res_cmd_start),
                        POS_W'(nick_len_in),
                        POS_W'(sender_len_in),
                        prefix_seen_in};
      if (req_fire && req_tlast) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_tlast)) begin
         phase_ff       <= PH_IDLE;
         byte_index_ff  <= '0;
         prefix_seen_ff <= 1'b0;
         sender_len_ff  <= '0;
         nick_len_ff    <= '0;
         bang_seen_ff   <= 1'b0;
         cmd_start_ff   <= '0;
         cmd_len_ff     <= '0;
         target_seen_ff <= 1'b0;
         tgt_start_ff   <= '0;
         tgt_len_ff     <= '0;
         msg_start_ff   <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         prefix_seen_ff <= prefix_seen_in;
         sender_len_ff  <= sender_len_in;
         nick_len_ff    <= nick_len_in;
         bang_seen_ff   <= bang_seen_in;
         cmd_start_ff   <= cmd_start_in;
         cmd_len_ff     <= cmd_len_in;
         target_seen_ff <= target_seen_in;
         tgt_start_ff   <= tgt_start_in;
         tgt_len_ff     <= tgt_len_in;
         msg_start_ff   <= msg_start_in;
         overflow_ff    <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // idle phase only at the start of a line
   a_idle_index : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (byte_index_ff == '0))
      else $error("idle phase with bytes counted");

   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= IDX_W'(MAX_LINE))
      else $error("byte index past line limit");

   a_last_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (rsp_valid_ff && (phase_ff == PH_IDLE)))
      else $error("last byte did not produce a result");

   a_no_target_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[41]) |-> (rsp_data_ff[61:42] == '0))
      else $error("target fields set without target");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> line_full)
      else $error("overflow flagged below line limit");

endmodule

`default_nettype wire
